/* hw/rtl/min_first_topological_sort_core_assert.svh */
// assertion macros for the min-first topological sort core
// expects clk and rst_n in the scope where a macro is used
`ifndef MIN_FIRST_TOPOLOGICAL_SORT_CORE_ASSERT_SVH
`define MIN_FIRST_TOPOLOGICAL_SORT_CORE_ASSERT_SVH

// same-cycle implication
`define MFTS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MFTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/mfts_pkg.sv */
// shared types and constants for the min-first topological sort core
// no dependencies
package mfts_pkg;

    localparam int NODE_COUNT_W = 7;
    localparam logic [NODE_COUNT_W-1:0] NODE_COUNT_RESET = 7'd64;
    localparam int GROUP_W = 8;

    localparam logic OP_EDGE = 1'b0;
    localparam logic OP_RUN  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DRAIN,
        ST_SEED,
        ST_PICK_GRP,
        ST_PICK_BIT,
        ST_HEAD,
        ST_ETGT,
        ST_EDEG,
        ST_FINISH
    } state_t;

endpackage

/* hw/rtl/min_first_topological_sort_core.sv */
// min-first topological sort core: edge store, in-degree and list-head memories
// depends on mfts_pkg and min_first_topological_sort_core_assert.svh
//
// Usage: an item is taken at a clock edge with start high and busy low.
// op 0 loads one edge (prerequisite_node before dependent_node); edge loads
// take one beat per cycle, a two-stage read-modify-write with forwarding
// between neighboring loads. op 1 runs the sort: busy stays high for the run,
// which drains, seeds, then per emitted node does a two-step lowest-bit search
// over the ready bitmap and a list-head read, per walked edge an edge memory
// read, then an in-degree read-modify-write, and ends with a closing step.
// Results appear one per strobe cycle; each emitted node shows up once its
// successor is found, the final one with last, complete and edge_overflow.
// The receiver cannot stall; results are never held off.
// A run with no ready node gives one result with node_id 0.
// Configuration: cfg_data is written into node_count on cfg_valid; cfg_ready
// is always high, and writes belong to idle periods only.
// Reset clears the store at once through per-node valid bits; the edge
// memory is not cleared, a fill count tracks it. The end of a run clears the
// store the same way.
module min_first_topological_sort_core #(
    parameter int NODES = 64,
    parameter int EDGES = 1024
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       op,
    input  logic [6:0] dependent_node,
    input  logic [6:0] prerequisite_node,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [6:0] cfg_data,
    output logic       strobe,
    output logic [6:0] node_id,
    output logic       last,
    output logic       complete,
    output logic       edge_overflow
);

    localparam int NW = $clog2(NODES);
    localparam int EW = $clog2(EDGES + 1);
    localparam int AW = $clog2(EDGES);
    localparam int NG = (NODES + mfts_pkg::GROUP_W - 1) / mfts_pkg::GROUP_W;
    localparam int GW = (NG > 1) ? $clog2(NG) : 1;
    localparam int PW = NG * mfts_pkg::GROUP_W;
    localparam int UW = GW + 3;
    localparam logic [EW-1:0] EMPTY = EW'(EDGES);

    // memories
    logic [EW-1:0]    deg_mem  [NODES];
    logic [EW-1:0]    head_mem [NODES];
    logic [NW+EW-1:0] edge_mem [EDGES];

    logic [EW-1:0]    deg_rd_reg, head_rd_reg;
    logic [NW+EW-1:0] edge_rd_reg;
    logic             deg_we, head_we, edge_we;
    logic [NW-1:0]    deg_waddr, deg_raddr, head_waddr, head_raddr;
    logic [EW-1:0]    deg_wdata, head_wdata;
    logic [AW-1:0]    edge_waddr, edge_raddr;
    logic [NW+EW-1:0] edge_wdata;

    mfts_pkg::state_t state_reg, state_next;

    logic [6:0]       node_count_reg, node_count_next;
    logic [NODES-1:0] deg_vld_reg, deg_vld_next;
    logic [NODES-1:0] head_vld_reg, head_vld_next;
    logic [NODES-1:0] ready_reg, ready_next;
    logic [NODES-1:0] emitted_reg, emitted_next;
    logic [EW-1:0]    fill_reg, fill_next;
    logic             overflow_reg, overflow_next;
    logic             deg_rd_vld_reg, deg_rd_vld_next;
    logic             head_rd_vld_reg, head_rd_vld_next;

    // edge load stage
    logic             s1_valid_reg, s1_valid_next;
    logic [NW-1:0]    s1_dep_reg, s1_dep_next;
    logic [NW-1:0]    s1_pre_reg, s1_pre_next;
    logic             s1_deg_byp_reg, s1_deg_byp_next;
    logic [EW-1:0]    s1_deg_bval_reg, s1_deg_bval_next;
    logic             s1_head_byp_reg, s1_head_byp_next;
    logic [EW-1:0]    s1_head_bval_reg, s1_head_bval_next;

    // run walk
    logic [GW-1:0]    grp_reg, grp_next;
    logic [NW-1:0]    pend_reg, pend_next;
    logic             pend_vld_reg, pend_vld_next;
    logic [NW-1:0]    tgt_reg, tgt_next;
    logic [EW-1:0]    enext_reg, enext_next;

    logic             accept, s1_wr, all_done, grp_found;
    logic [EW-1:0]    deg_old, head_old, head_e, deg_cur;
    logic [NW-1:0]    dep_idx, pre_idx, u_idx;
    logic [6:0]       n_eff;
    logic [NODES-1:0] mask_n;
    logic [PW-1:0]    ready_pad;
    logic [7:0]       grp_bits;
    logic [2:0]       bit_sel;
    logic [GW-1:0]    grp_sel;
    logic             in_range;

    assign busy      = (state_reg != mfts_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;
    assign dep_idx   = NW'(dependent_node - 7'd1);
    assign pre_idx   = NW'(prerequisite_node - 7'd1);
    assign in_range  = (dependent_node != 7'd0) && (dependent_node <= 7'(NODES))
                    && (prerequisite_node != 7'd0) && (prerequisite_node <= 7'(NODES));

    assign s1_wr    = s1_valid_reg && (fill_reg < EMPTY);
    assign deg_old  = s1_deg_byp_reg ? s1_deg_bval_reg
                    : (deg_rd_vld_reg ? deg_rd_reg : '0);
    assign head_old = s1_head_byp_reg ? s1_head_bval_reg
                    : (head_rd_vld_reg ? head_rd_reg : EMPTY);
    assign head_e   = head_rd_vld_reg ? head_rd_reg : EMPTY;
    assign deg_cur  = deg_rd_vld_reg ? deg_rd_reg : '0;

    // node count clamp and mask of seeded nodes
    always_comb
    begin
        if (node_count_reg == 7'd0)
            n_eff = 7'd1;
        else if (node_count_reg > 7'(NODES))
            n_eff = 7'(NODES);
        else
            n_eff = node_count_reg;
        for (int i = 0; i < NODES; i++)
            mask_n[i] = (7'(i) < n_eff);
    end

    assign all_done = &(emitted_reg | ~mask_n);

    // two-step lowest ready node: group of eight, then bit in group
    assign ready_pad = PW'(ready_reg);
    always_comb
    begin
        grp_sel   = '0;
        grp_found = 1'b0;
        for (int g = NG - 1; g >= 0; g--)
        begin
            if (|ready_pad[g*8 +: 8])
            begin
                grp_sel   = GW'(g);
                grp_found = 1'b1;
            end
        end
        grp_bits = ready_pad[{grp_reg, 3'b000} +: 8];
        bit_sel  = 3'd0;
        for (int b = 7; b >= 0; b--)
            if (grp_bits[b])
                bit_sel = 3'(b);
        u_idx = NW'({grp_reg, bit_sel});
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mfts_pkg::ST_IDLE:
                if (accept && op == mfts_pkg::OP_RUN)
                    state_next = mfts_pkg::ST_DRAIN;
            mfts_pkg::ST_DRAIN:    state_next = mfts_pkg::ST_SEED;
            mfts_pkg::ST_SEED:     state_next = mfts_pkg::ST_PICK_GRP;
            mfts_pkg::ST_PICK_GRP:
                state_next = grp_found ? mfts_pkg::ST_PICK_BIT : mfts_pkg::ST_FINISH;
            mfts_pkg::ST_PICK_BIT: state_next = mfts_pkg::ST_HEAD;
            mfts_pkg::ST_HEAD:
                state_next = (head_e == EMPTY) ? mfts_pkg::ST_PICK_GRP : mfts_pkg::ST_ETGT;
            mfts_pkg::ST_ETGT:     state_next = mfts_pkg::ST_EDEG;
            mfts_pkg::ST_EDEG:
                state_next = (enext_reg == EMPTY) ? mfts_pkg::ST_PICK_GRP
                                                  : mfts_pkg::ST_ETGT;
            mfts_pkg::ST_FINISH:   state_next = mfts_pkg::ST_IDLE;
            default:               state_next = mfts_pkg::ST_IDLE;
        endcase
    end

    // result outputs
    always_comb
    begin
        strobe        = 1'b0;
        node_id       = 7'd0;
        last          = 1'b0;
        complete      = 1'b0;
        edge_overflow = 1'b0;
        case (state_reg)
            mfts_pkg::ST_PICK_BIT:
            begin
                strobe  = pend_vld_reg;
                node_id = 7'(pend_reg) + 7'd1;
            end
            mfts_pkg::ST_FINISH:
            begin
                strobe        = 1'b1;
                node_id       = pend_vld_reg ? 7'(pend_reg) + 7'd1 : 7'd0;
                last          = 1'b1;
                complete      = pend_vld_reg && all_done;
                edge_overflow = overflow_reg;
            end
            default:
            begin
                strobe = 1'b0;
            end
        endcase
    end

    // datapath and memory ports
    always_comb
    begin
        node_count_next   = cfg_valid ? cfg_data : node_count_reg;
        deg_vld_next      = deg_vld_reg;
        head_vld_next     = head_vld_reg;
        ready_next        = ready_reg;
        emitted_next      = emitted_reg;
        fill_next         = fill_reg;
        overflow_next     = overflow_reg;
        s1_valid_next     = 1'b0;
        s1_dep_next       = dep_idx;
        s1_pre_next       = pre_idx;
        s1_deg_byp_next   = s1_wr && (s1_dep_reg == dep_idx);
        s1_deg_bval_next  = deg_old + EW'(1);
        s1_head_byp_next  = s1_wr && (s1_pre_reg == pre_idx);
        s1_head_bval_next = fill_reg;
        grp_next          = grp_reg;
        pend_next         = pend_reg;
        pend_vld_next     = pend_vld_reg;
        tgt_next          = tgt_reg;
        enext_next        = enext_reg;

        deg_we     = 1'b0;
        deg_waddr  = s1_dep_reg;
        deg_wdata  = deg_old + EW'(1);
        head_we    = 1'b0;
        head_waddr = s1_pre_reg;
        head_wdata = fill_reg;
        edge_we    = 1'b0;
        edge_waddr = fill_reg[AW-1:0];
        edge_wdata = {s1_dep_reg, head_old};
        deg_raddr  = dep_idx;
        head_raddr = pre_idx;
        edge_raddr = '0;

        // second half of an edge load
        if (s1_valid_reg)
        begin
            if (s1_wr)
            begin
                deg_we                    = 1'b1;
                head_we                   = 1'b1;
                edge_we                   = 1'b1;
                deg_vld_next[s1_dep_reg]  = 1'b1;
                head_vld_next[s1_pre_reg] = 1'b1;
                fill_next                 = fill_reg + EW'(1);
            end
            else
            begin
                overflow_next = 1'b1;
            end
        end

        case (state_reg)
            mfts_pkg::ST_IDLE:
                if (accept && op == mfts_pkg::OP_EDGE)
                    s1_valid_next = in_range;
            mfts_pkg::ST_SEED:
            begin
                ready_next    = ~deg_vld_reg & mask_n;
                emitted_next  = '0;
                pend_vld_next = 1'b0;
            end
            mfts_pkg::ST_PICK_GRP:
                grp_next = grp_sel;
            mfts_pkg::ST_PICK_BIT:
            begin
                ready_next[u_idx]   = 1'b0;
                emitted_next[u_idx] = 1'b1;
                head_raddr          = u_idx;
                pend_next           = u_idx;
                pend_vld_next       = 1'b1;
            end
            mfts_pkg::ST_HEAD:
                edge_raddr = head_e[AW-1:0];
            mfts_pkg::ST_ETGT:
            begin
                tgt_next   = edge_rd_reg[NW+EW-1:EW];
                enext_next = edge_rd_reg[EW-1:0];
                deg_raddr  = edge_rd_reg[NW+EW-1:EW];
            end
            mfts_pkg::ST_EDEG:
            begin
                edge_raddr = enext_reg[AW-1:0];
                if (deg_cur != '0)
                begin
                    deg_we    = 1'b1;
                    deg_waddr = tgt_reg;
                    deg_wdata = deg_cur - EW'(1);
                    if (deg_cur == EW'(1))
                        ready_next[tgt_reg] = 1'b1;
                end
            end
            mfts_pkg::ST_FINISH:
            begin
                deg_vld_next  = '0;
                head_vld_next = '0;
                ready_next    = '0;
                emitted_next  = '0;
                fill_next     = '0;
                overflow_next = 1'b0;
                pend_vld_next = 1'b0;
            end
            default:
            begin
                s1_valid_next = 1'b0;
            end
        endcase

        // valid bits sampled with the read so they line up with the data
        deg_rd_vld_next  = deg_vld_reg[deg_raddr];
        head_rd_vld_next = head_vld_reg[head_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (deg_we)
            deg_mem[deg_waddr] <= deg_wdata;
        deg_rd_reg <= deg_mem[deg_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (head_we)
            head_mem[head_waddr] <= head_wdata;
        head_rd_reg <= head_mem[head_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (edge_we)
            edge_mem[edge_waddr] <= edge_wdata;
        edge_rd_reg <= edge_mem[edge_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= mfts_pkg::ST_IDLE;
            node_count_reg <= mfts_pkg::NODE_COUNT_RESET;
            deg_vld_reg    <= '0;
            head_vld_reg   <= '0;
            ready_reg      <= '0;
            emitted_reg    <= '0;
            fill_reg       <= '0;
            overflow_reg   <= 1'b0;
            s1_valid_reg   <= 1'b0;
            pend_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            node_count_reg <= node_count_next;
            deg_vld_reg    <= deg_vld_next;
            head_vld_reg   <= head_vld_next;
            ready_reg      <= ready_next;
            emitted_reg    <= emitted_next;
            fill_reg       <= fill_next;
            overflow_reg   <= overflow_next;
            s1_valid_reg   <= s1_valid_next;
            pend_vld_reg   <= pend_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        deg_rd_vld_reg   <= deg_rd_vld_next;
        head_rd_vld_reg  <= head_rd_vld_next;
        s1_dep_reg       <= s1_dep_next;
        s1_pre_reg       <= s1_pre_next;
        s1_deg_byp_reg   <= s1_deg_byp_next;
        s1_deg_bval_reg  <= s1_deg_bval_next;
        s1_head_byp_reg  <= s1_head_byp_next;
        s1_head_bval_reg <= s1_head_bval_next;
        grp_reg          <= grp_next;
        pend_reg         <= pend_next;
        tgt_reg          <= tgt_next;
        enext_reg        <= enext_next;
    end

`include "min_first_topological_sort_core_assert.svh"

    `MFTS_ASSERT_NOW(a_strobe_busy, strobe, busy, "result beat outside a run")
    `MFTS_ASSERT_NEXT(a_last_ends_run, strobe && last, !busy, "run did not end after last")
    `MFTS_ASSERT_NOW(a_complete_last, strobe && complete, last, "complete without last")
    `MFTS_ASSERT_NOW(a_fill_bound, 1'b1, fill_reg <= EMPTY, "edge fill past capacity")
    `MFTS_ASSERT_NOW(a_load_drained, state_reg == mfts_pkg::ST_SEED, !s1_valid_reg,
        "edge load still pending at seed")

endmodule

/* bench/min_first_topological_sort_core_test.sv */
// self-checking bench for the min-first topological sort core
// drives edge loads, sort runs and node_count writes; depends on mfts_pkg
`timescale 1ns / 100ps

class topo_scoreboard;
    logic [6:0] want_node[$];
    logic       want_last[$];
    logic       want_complete[$];
    logic       want_ovf[$];
    int unsigned errors;
    int unsigned runs;
    int unsigned results_seen;

    // graph copy kept by the predictor
    int unsigned node_cnt;
    int unsigned indeg[64];
    int unsigned succ[64][$];
    int unsigned fill;
    bit          ovf;

    function new();
        node_cnt = 64;
        errors = 0;
        runs = 0;
        results_seen = 0;
        clear_graph();
    endfunction

    function void clear_graph();
        for (int i = 0; i < 64; i++)
        begin
            indeg[i] = 0;
            succ[i].delete();
        end
        fill = 0;
        ovf = 0;
    endfunction

    function void set_count(logic [6:0] v);
        node_cnt = v;
    endfunction

    function void push_result(logic [6:0] n, logic l, logic c, logic o);
        want_node.insert(want_node.size(), n);
        want_last.insert(want_last.size(), l);
        want_complete.insert(want_complete.size(), c);
        want_ovf.insert(want_ovf.size(), o);
    endfunction

    // note one accepted input beat and predict its results
    function void note_input(logic op_i, logic [6:0] dep, logic [6:0] pre);
        int unsigned n;
        int unsigned cnt;
        int unsigned u;
        int unsigned t;
        logic [63:0] rdy;
        logic [63:0] done;
        bit all;
        logic [6:0] order[$];
        if (op_i == mfts_pkg::OP_EDGE)
        begin
            if (dep < 1 || dep > 64 || pre < 1 || pre > 64)
                return;
            if (fill >= 1024)
            begin
                ovf = 1;
                return;
            end
            // newest edge walked first, like the linked list head insert
            succ[pre-1].push_front(dep - 1);
            fill++;
            indeg[dep-1]++;
            return;
        end
        runs++;
        n = node_cnt < 1 ? 1 : (node_cnt > 64 ? 64 : node_cnt);
        rdy = '0;
        done = '0;
        cnt = 0;
        for (int i = 0; i < n; i++)
            if (indeg[i] == 0)
                rdy[i] = 1'b1;
        while (rdy != 0 && cnt < 64)
        begin
            u = 0;
            while (!rdy[u])
                u++;
            rdy[u] = 1'b0;
            done[u] = 1'b1;
            order.insert(order.size(), 7'(u + 1));
            cnt++;
            foreach (succ[u][k])
            begin
                t = succ[u][k];
                if (indeg[t] > 0)
                begin
                    indeg[t]--;
                    if (indeg[t] == 0)
                        rdy[t] = 1'b1;
                end
            end
        end
        all = 1;
        for (int i = 0; i < n; i++)
            if (!done[i])
                all = 0;
        if (cnt == 0)
            push_result(7'd0, 1'b1, 1'b0, ovf);
        else
            for (int i = 0; i < cnt; i++)
                if (i == cnt - 1)
                    push_result(order[i], 1'b1, all, ovf);
                else
                    push_result(order[i], 1'b0, 1'b0, 1'b0);
        clear_graph();
    endfunction

    task report(string what, int got, int exp_v);
        errors++;
        $display("mismatch on %s: got %0d, expected %0d", what, got, exp_v);
    endtask

    task check_result(logic [6:0] n, logic l, logic c, logic o);
        results_seen++;
        if (want_node.size() == 0)
        begin
            report("unexpected result beat node_id", n, -1);
            return;
        end
        if (n !== want_node[0]) report("node_id", n, want_node[0]);
        if (l !== want_last[0]) report("last", l, want_last[0]);
        if (c !== want_complete[0]) report("complete", c, want_complete[0]);
        if (o !== want_ovf[0]) report("edge_overflow", o, want_ovf[0]);
        void'(want_node.pop_front());
        void'(want_last.pop_front());
        void'(want_complete.pop_front());
        void'(want_ovf.pop_front());
    endtask
endclass

module min_first_topological_sort_core_test;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic       op;
    logic [6:0] dependent_node;
    logic [6:0] prerequisite_node;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [6:0] cfg_data;
    logic       strobe;
    logic [6:0] node_id;
    logic       last;
    logic       complete;
    logic       edge_overflow;

    topo_scoreboard sb;
    int unsigned cycles = 0;
    int unsigned beats;

    min_first_topological_sort_core DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .op(op),
        .dependent_node(dependent_node), .prerequisite_node(prerequisite_node),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .strobe(strobe), .node_id(node_id), .last(last), .complete(complete),
        .edge_overflow(edge_overflow)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    initial
    begin
        sb = new();
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 3000000)
        begin
            $display("timeout");
            $display("Mismatches found");
            $finish;
        end
        if (rst_n && strobe)
            sb.check_result(node_id, last, complete, edge_overflow);
    end

    // one input beat; gap drawn per item, start stays high into the next item
    task automatic send_item(logic op_i, logic [6:0] dep, logic [6:0] pre, int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        op <= op_i;
        dependent_node <= dep;
        prerequisite_node <= pre;
        @(posedge clk);
        while (busy) @(posedge clk);
        sb.note_input(op_i, dep, pre);
        beats++;
    endtask

    task automatic edge_beat(logic [6:0] dep, logic [6:0] pre);
        send_item(mfts_pkg::OP_EDGE, dep, pre,
                  ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 19)) : 0);
    endtask

    task automatic run_beat();
        send_item(mfts_pkg::OP_RUN, 7'($urandom), 7'($urandom), int'($urandom_range(0, 19)));
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.want_node.size() != 0) @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    task automatic write_count(logic [6:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.set_count(v);
        cfg_valid <= 1'b0;
    endtask

    // random graph: mostly forward edges within the node range, some noise
    task automatic random_graph(int unsigned n, int unsigned edges);
        int unsigned a;
        int unsigned b;
        for (int i = 0; i < edges; i++)
        begin
            a = $urandom_range(1, n);
            b = $urandom_range(1, n);
            if ($urandom_range(0, 19) == 0)
                edge_beat(7'($urandom), 7'($urandom));
            else if ($urandom_range(0, 9) == 0 || a == b)
                edge_beat(7'(a), 7'(b));
            else if (a < b)
                edge_beat(7'(b), 7'(a));
            else
                edge_beat(7'(a), 7'(b));
        end
        run_beat();
    endtask

    initial
    begin
        int unsigned n;
        beats = 0;
        rst_n = 1'b0;
        start = 1'b0;
        op = mfts_pkg::OP_EDGE;
        dependent_node = '0;
        prerequisite_node = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty graph at reset count, extremes, self edge, cycle
        run_beat();
        edge_beat(7'd64, 7'd1);
        edge_beat(7'd1, 7'd64);
        edge_beat(7'd0, 7'd5);
        edge_beat(7'd127, 7'd3);
        edge_beat(7'd5, 7'd0);
        run_beat();
        write_count(7'd1);
        edge_beat(7'd1, 7'd1);
        run_beat();
        write_count(7'd0);
        run_beat();
        write_count(7'd127);
        edge_beat(7'd2, 7'd1);
        edge_beat(7'd3, 7'd2);
        run_beat();
        write_count(7'd3);
        edge_beat(7'd5, 7'd1);
        edge_beat(7'd2, 7'd1);
        edge_beat(7'd2, 7'd3);
        run_beat();
        edge_beat(7'd1, 7'd2);
        edge_beat(7'd2, 7'd1);
        edge_beat(7'd3, 7'd3);
        run_beat();
        write_count(7'd8);

        // random phases with occasional count changes
        while (beats < 470)
        begin
            n = $urandom_range(0, 3) == 0 ? $urandom_range(1, 64) : $urandom_range(1, 10);
            if ($urandom_range(0, 3) == 0)
                write_count($urandom_range(0, 9) == 0 ? 7'($urandom) : 7'(n));
            if ($urandom_range(0, 7) == 0)
                drain();
            random_graph(n, $urandom_range(0, 12));
        end
        write_count(7'd64);
        random_graph(64, 20);

        drain();
        $display("covered %0d input beats, %0d sort runs, %0d result beats",
                 beats, sb.runs, sb.results_seen);
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
